// ===== rtl/lzpk_pkg.sv =====
package lzpk_pkg;

  localparam int MAX_CODE_WIDTH = 16;
  localparam int CODE_LIMIT = (MAX_CODE_WIDTH < 16) ? MAX_CODE_WIDTH : 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    REQ_PACK  = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  // One queued job: up to three packed bytes and how many of them are valid.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  byte_count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_read_t;

endpackage

// ===== rtl/lzpk_request_if.sv =====
interface lzpk_request_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] code_value;
  logic [4:0]  code_width;
  logic [7:0]  symbol_value;

  modport source(output valid, req_type, code_value, code_width, symbol_value, input ready);
  modport sink(input valid, req_type, code_value, code_width, symbol_value, output ready);
endinterface

// ===== rtl/lzpk_result_if.sv =====
interface lzpk_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, out_byte, last_of_run, input ready);
  modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

// ===== rtl/lzpk_front.sv =====
module lzpk_front
  import lzpk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lzpk_request_if.sink request,
  input  logic queue_full,
  output logic push,
  output job_t push_job
);

  localparam logic [4:0] LIMIT_W = 5'(CODE_LIMIT);

  logic [6:0]  pending_bits;
  logic [6:0]  pending_bits_next;
  logic [2:0]  pending_count;
  logic [2:0]  pending_count_next;
  logic        accept;
  logic [4:0]  width;
  logic [16:0] ones;
  logic [15:0] code;
  logic [30:0] acc;
  logic [30:0] rest;
  logic [4:0]  total;

  assign request.ready = !queue_full;
  assign accept = request.valid && request.ready;

  always_comb begin
    width = (request.code_width > LIMIT_W) ? LIMIT_W : request.code_width;
    ones = (17'd1 << width) - 17'd1;
    code = request.code_value & ones[15:0];
    acc = {24'd0, pending_bits} | ({15'd0, code} << pending_count)
        | ({23'd0, request.symbol_value} << (5'(pending_count) + width));
    total = 5'(pending_count) + width + 5'd8;
    rest = acc >> {total[4:3], 3'b000};

    push = 1'b0;
    push_job.data = acc[23:0];
    push_job.byte_count = total[4:3];
    pending_bits_next = pending_bits;
    pending_count_next = pending_count;
    if (request.req_type == REQ_FLUSH) begin
      push = accept && (pending_count != 3'd0);
      push_job.data = {17'd0, pending_bits};
      push_job.byte_count = 2'd1;
      pending_bits_next = 7'd0;
      pending_count_next = 3'd0;
    end else begin
      push = accept;
      pending_bits_next = rest[6:0];
      pending_count_next = total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= 7'd0;
      pending_count <= 3'd0;
    end else if (accept) begin
      pending_bits <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== rtl/lzpk_queue.sv =====
module lzpk_queue
  import lzpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  output logic        full,
  input  queue_read_t rd,
  output logic        head_valid,
  output job_t        head_job
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   pop;

  assign full = (fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job = entries[rd_ptr];
  assign pop = rd.pop && rd.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lzpk_back.sv =====
module lzpk_back
  import lzpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head_job,
  output queue_read_t rd,
  lzpk_result_if.source result
);

  logic [1:0] byte_index;
  logic       load;
  logic       is_last;
  logic [7:0] next_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_of_run;

  assign load = head_valid && (!out_valid || result.ready);
  assign is_last = (byte_index == head_job.byte_count - 2'd1);
  assign rd.valid = head_valid;
  assign rd.pop = load && is_last;

  always_comb begin
    case (byte_index)
      2'd0: next_byte = head_job.data[7:0];
      2'd1: next_byte = head_job.data[15:8];
      2'd2: next_byte = head_job.data[23:16];
      default: next_byte = 8'd0;
    endcase
  end

  assign result.valid = out_valid;
  assign result.out_byte = out_byte;
  assign result.last_of_run = last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_index <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        byte_index <= is_last ? 2'd0 : byte_index + 2'd1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= next_byte;
      last_of_run <= is_last;
    end
  end

endmodule

// ===== rtl/lz78_pair_bit_packer_unit.sv =====
// Packs LZ78 code/symbol pairs into a byte stream, least significant bit first.
// A pair request adds its code (width saturated to the supported maximum) and its
// symbol to the held bits and yields one to three bytes; a flush yields the held
// partial byte, zero padded, or nothing if no bit is held. The front end takes one
// request per cycle while its job queue has room, and the byte-wide output register
// sends one byte per cycle while result.ready is high; new requests can be taken
// while earlier bytes drain. The last byte of each request carries last_of_run.
// No reset sweep is needed; the block is ready in the cycle after reset.
module lz78_pair_bit_packer_unit
  import lzpk_pkg::*;
(
  input logic clk,
  input logic rst,
  lzpk_request_if.sink request,
  lzpk_result_if.source result
);

  logic        push;
  job_t        push_job;
  logic        queue_full;
  queue_read_t rd;
  logic        head_valid;
  job_t        head_job;

  lzpk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  lzpk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .rd         (rd),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lzpk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .rd         (rd),
    .result     (result)
  );

endmodule
